// ===== src/tone_sequence_player_top_defines.svh =====
// assertion macros for the tone sequence player checker
`ifndef TONE_SEQUENCE_PLAYER_TOP_DEFINES_SVH
`define TONE_SEQUENCE_PLAYER_TOP_DEFINES_SVH

// same-cycle implication, checked only out of reset
`define TSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tone sequence player check failed");

// next-cycle implication, checked only out of reset
`define TSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tone sequence player check failed");

`endif

// ===== src/tsp_pkg.sv =====
// shared constants and control types of the tone sequence player
`timescale 1ns / 1ps

package tsp_pkg;

  localparam int DEPTH      = 64;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int IN_VAL_W   = 16;
  localparam int STEP_W     = 15;
  localparam int FREQ_W     = 15;
  localparam int TIME_W     = 16;
  localparam int OUT_IDX_W  = 7;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic entry_go;
    logic tick_go;
    logic start_go;
    logic emit;
  } tsp_cmd_t;

  typedef struct packed {
    logic start_pend;
  } tsp_status_t;

endpackage

// ===== src/tsp_ctrl.sv =====
// controller state machine: item sequencing and the output handshake
`timescale 1ns / 1ps

module tsp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_mode,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output tsp_pkg::tsp_cmd_t    cmd,
  input  tsp_pkg::tsp_status_t status
);
  import tsp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.entry_go = !in_mode;
          cmd.tick_go  = in_mode;
          state_nxt    = in_mode ? S_TICK : S_EMIT;
        end
      end
      S_TICK: begin
        // memory data for the note to start is ready now
        cmd.start_go = status.start_pend;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/tsp_dp.sv =====
// datapath: note memory, playback state and the result register
`timescale 1ns / 1ps

module tsp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tsp_pkg::tsp_cmd_t                 cmd,
  output tsp_pkg::tsp_status_t              status,
  input  logic                              in_first,
  input  logic                              in_last,
  input  logic signed [tsp_pkg::IN_VAL_W-1:0] in_freq,
  input  logic signed [tsp_pkg::IN_VAL_W-1:0] in_dur,
  input  logic [tsp_pkg::STEP_W-1:0]        in_step,
  output logic [tsp_pkg::OUT_DATA_W-1:0]    out_data
);
  import tsp_pkg::*;

  logic [FREQ_W-1:0]        freq_mem [DEPTH];
  logic [FREQ_W-1:0]        len_mem  [DEPTH];

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         idx_r;
  logic signed [TIME_W-1:0] rem_r;
  logic                     closed_r;
  logic                     sounding_r;
  logic [FREQ_W-1:0]        cur_freq_r;
  logic                     start_pend_r;
  logic [FREQ_W-1:0]        rd_freq_r;
  logic [FREQ_W-1:0]        rd_len_r;
  logic [OUT_DATA_W-1:0]    out_data_r;

  // entry path
  logic [CNT_W-1:0]         cnt_base;
  logic                     closed_base;
  logic                     bad_value;
  logic                     has_room;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;

  // tick path
  logic signed [TIME_W:0]   rem_sub;
  logic                     rem_le0;
  logic                     sub_le0;
  logic                     have_notes;
  logic                     runs_out;
  logic [CNT_W-1:0]         idx_next;
  logic [ADDR_W-1:0]        rd_addr;
  logic [FREQ_W-1:0]        shown_freq;

  assign cnt_base    = in_first ? '0 : count_r;
  assign closed_base = in_first ? 1'b0 : closed_r;
  assign bad_value   = (in_freq <= 0) || (in_dur <= 0);
  assign has_room    = (cnt_base < CNT_W'(DEPTH));
  assign wr_en       = cmd.entry_go && !closed_base && !bad_value && has_room;
  assign wr_addr     = cnt_base[ADDR_W-1:0];

  assign rem_sub    = $signed({rem_r[TIME_W-1], rem_r}) - $signed({2'b00, in_step});
  assign rem_le0    = rem_r[TIME_W-1] || (rem_r == '0);
  assign sub_le0    = rem_sub[TIME_W] || (rem_sub == '0);
  assign have_notes = (count_r != '0);
  assign runs_out   = have_notes && !rem_le0 && sub_le0;
  // advance only while notes remain; an index at the count reads nothing useful
  assign idx_next   = (runs_out && (idx_r < count_r)) ? idx_r + 1'b1 : idx_r;
  assign rd_addr    = idx_next[ADDR_W-1:0];

  assign status.start_pend = start_pend_r;
  assign shown_freq        = sounding_r ? cur_freq_r : '0;
  assign out_data          = out_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      freq_mem[wr_addr] <= in_freq[FREQ_W-1:0];
      len_mem[wr_addr]  <= in_dur[FREQ_W-1:0];
    end
    if (cmd.tick_go) begin
      rd_freq_r <= freq_mem[rd_addr];
      rd_len_r  <= len_mem[rd_addr];
    end
    if (cmd.emit) begin
      out_data_r <= {2'b00, OUT_IDX_W'(count_r), OUT_IDX_W'(idx_r), shown_freq, sounding_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      idx_r        <= '0;
      rem_r        <= '0;
      closed_r     <= 1'b0;
      sounding_r   <= 1'b0;
      cur_freq_r   <= '0;
      start_pend_r <= 1'b0;
    end else begin
      if (cmd.entry_go) begin
        if (in_first) begin
          idx_r      <= '0;
          rem_r      <= '0;
          sounding_r <= 1'b0;
          cur_freq_r <= '0;
        end
        count_r  <= wr_en ? cnt_base + 1'b1 : cnt_base;
        closed_r <= closed_base || bad_value || in_last;
      end
      if (cmd.tick_go) begin
        start_pend_r <= have_notes && (rem_le0 || sub_le0);
        if (have_notes && !rem_le0) begin
          rem_r <= rem_sub[TIME_W-1:0];
          if (sub_le0) begin
            sounding_r <= 1'b0;
            cur_freq_r <= '0;
            idx_r      <= idx_next;
          end
        end
      end
      if (cmd.start_go && (idx_r < count_r)) begin
        sounding_r <= 1'b1;
        cur_freq_r <= rd_freq_r;
        rem_r      <= {1'b0, rd_len_r};
      end
    end
  end

endmodule

// ===== src/tone_sequence_player_top.sv =====
// Tone sequence player: stores a list of notes and steps through them on ticks.
// Input channel in_*: in_tuser[0] = mode (0 entry, 1 tick), in_tuser[1] = first
// entry flag, in_tlast = last entry mark; in_tdata carries frequency, duration
// and tick step. Entries append notes to a 64-entry note memory; a first entry
// restarts the list, a non-positive value or the last mark closes it.
// Result channel out_*: one result per accepted item with tone on flag, sounding
// frequency, current note index and stored note count.
// out_tvalid rises once the EMIT state loads the output register: an entry goes
// to EMIT straight from IDLE, a tick passes through TICK first, since the tick
// reads the note memory through a registered port. A new item is taken again
// once its result sits in the output register, not while one is in progress.
// The output register holds its result while out_tready is low; the block can
// take one further item meanwhile and then waits with in_tready low.
// Reset (rst_n low, synchronous) empties the list, silences the tone and drops
// any waiting result; note memory contents are not cleared.
`timescale 1ns / 1ps

module tone_sequence_player_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] frequency, [31:16] duration, [46:32] step, [47] zero
  input  logic [tsp_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] mode, [1] first_entry
  input  logic [tsp_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] tone_on, [15:1] tone_frequency, [22:16] note_index, [29:23] note_count,
  // [31:30] zero
  output logic [tsp_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import tsp_pkg::*;

  tsp_cmd_t    cmd;
  tsp_status_t status;

  tsp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  tsp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_first (in_tuser[1]),
    .in_last  (in_tlast),
    .in_freq  ($signed(in_tdata[15:0])),
    .in_dur   ($signed(in_tdata[31:16])),
    .in_step  (in_tdata[46:32]),
    .out_data (out_tdata)
  );

endmodule

// ===== src/tsp_checker.sv =====
// port-level checks for the tone sequence player and their bind
`timescale 1ns / 1ps
`include "tone_sequence_player_top_defines.svh"

module tsp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tsp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tsp_pkg::*;

  // a stalled result keeps its payload
  `TSP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // silence shows a zero frequency
  `TSP_ASSERT_NOW(a_silent_zero, out_tvalid && !out_tdata[0], out_tdata[15:1] == '0)

  // playback never runs past the stored notes
  `TSP_ASSERT_NOW(a_idx_le_cnt, out_tvalid, out_tdata[22:16] <= out_tdata[29:23])

  // the note count never exceeds the memory depth
  `TSP_ASSERT_NOW(a_cnt_le_depth, out_tvalid, out_tdata[29:23] <= OUT_IDX_W'(DEPTH))

endmodule

bind tone_sequence_player_top tsp_checker u_tsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
